[src/lru_kvc_pkg.sv]
package lru_kvc_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int ENTRIES_MAX = 64;
  localparam int SLOT_W_MAX  = 6;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic                    opcode;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_W_MAX-1:0] hit_idx;
    logic                  free_ok;
    logic [SLOT_W_MAX-1:0] free_idx;
    logic                  victim_ok;
    logic [SLOT_W_MAX-1:0] victim_idx;
  } lookup_t;

endpackage

[src/lru_kvc_match.sv]
module lru_kvc_match #(
  parameter int ENTRIES = lru_kvc_pkg::ENTRIES_DEF
) (
  input  logic [ENTRIES-1:0][lru_kvc_pkg::KEY_W-1:0] key_tbl,
  input  logic [ENTRIES-1:0]                         valid,
  input  logic [ENTRIES-1:0][((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rank,
  input  logic [$clog2(ENTRIES+1)-1:0]               count,
  input  logic [lru_kvc_pkg::KEY_W-1:0]              key,
  output lru_kvc_pkg::lookup_t                       lk
);

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  logic [RANK_W-1:0] victim_rank;

  // oldest valid entry holds rank count-1
  assign victim_rank = RANK_W'(count - CNT_W'(1));

  always_comb begin
    lk = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid[i] && key_tbl[i] == key) begin
        lk.hit     = 1'b1;
        lk.hit_idx = lru_kvc_pkg::SLOT_W_MAX'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        lk.free_ok  = 1'b1;
        lk.free_idx = lru_kvc_pkg::SLOT_W_MAX'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && rank[i] == victim_rank) begin
        lk.victim_ok  = 1'b1;
        lk.victim_idx = lru_kvc_pkg::SLOT_W_MAX'(i);
      end
    end
  end

endmodule

[src/lru_key_value_cache.sv]
// LRU key-value cache, fully associative, parallel key compare.
// The start beat and request are registered, then done and rsp are registered from that stage.
// Throughput: one access per cycle; busy stays low, the receiver cannot stall.
// Reset (rst, synchronous): valid marks, ranks, fill count cleared,
// capacity back to 16; stored keys/values are not cleared.
module lru_key_value_cache #(
  parameter int ENTRIES = lru_kvc_pkg::ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  lru_kvc_pkg::req_t                req,
  output logic                             done,
  output lru_kvc_pkg::rsp_t                rsp,
  input  logic                             cfg_we,
  input  logic [lru_kvc_pkg::CAP_W-1:0]    cfg_wdata
);

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IDX_W  = RANK_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int LIM_W  = (CNT_W > lru_kvc_pkg::CAP_W) ? CNT_W : lru_kvc_pkg::CAP_W;

  logic                                       s_valid;
  lru_kvc_pkg::req_t                          s_req;
  logic [lru_kvc_pkg::CAP_W-1:0]              capacity;
  logic [CNT_W-1:0]                           count, count_next;
  logic [ENTRIES-1:0]                         valid, valid_next;
  logic [ENTRIES-1:0][RANK_W-1:0]             rank, rank_next;
  logic [ENTRIES-1:0][lru_kvc_pkg::KEY_W-1:0] keys;
  logic [ENTRIES-1:0][lru_kvc_pkg::VAL_W-1:0] values;
  lru_kvc_pkg::rsp_t                          rsp_next;
  lru_kvc_pkg::lookup_t                       lk;

  logic              val_we, key_we;
  logic [IDX_W-1:0]  wr_idx, hit_idx, slot;
  logic [RANK_W-1:0] old_rank;
  logic [LIM_W-1:0]  limit, cap_ext;
  logic              room;

  assign busy = 1'b0;

  lru_kvc_match #(.ENTRIES(ENTRIES)) u_match (
    .key_tbl (keys),
    .valid   (valid),
    .rank    (rank),
    .count   (count),
    .key     (s_req.key),
    .lk      (lk)
  );

  assign cap_ext  = LIM_W'(capacity);
  assign hit_idx  = lk.hit_idx[IDX_W-1:0];
  assign old_rank = rank[hit_idx];

  always_comb begin
    if (capacity == '0) begin
      limit = LIM_W'(1);
    end else if (cap_ext > LIM_W'(ENTRIES)) begin
      limit = LIM_W'(ENTRIES);
    end else begin
      limit = cap_ext;
    end
  end

  assign room = (LIM_W'(count) < limit) && lk.free_ok;

  always_comb begin
    if (room) begin
      slot = lk.free_idx[IDX_W-1:0];
    end else if (lk.victim_ok) begin
      slot = lk.victim_idx[IDX_W-1:0];
    end else begin
      slot = '0;
    end
  end

  always_comb begin
    valid_next = valid;
    rank_next  = rank;
    count_next = count;
    val_we     = 1'b0;
    key_we     = 1'b0;
    wr_idx     = slot;
    rsp_next   = '0;
    if (s_valid) begin
      if (lk.hit) begin
        // promote: younger entries age by one
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid[i] && IDX_W'(i) != hit_idx && rank[i] < old_rank) begin
            rank_next[i] = rank[i] + RANK_W'(1);
          end
        end
        rank_next[hit_idx] = '0;
        rsp_next.hit       = 1'b1;
        wr_idx             = hit_idx;
        if (s_req.opcode == lru_kvc_pkg::OP_PUT) begin
          val_we = 1'b1;
        end else begin
          rsp_next.read_value = values[hit_idx];
        end
      end else if (s_req.opcode == lru_kvc_pkg::OP_GET) begin
        rsp_next.read_value = lru_kvc_pkg::MISS_VALUE;
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid[i] && IDX_W'(i) != slot) begin
            rank_next[i] = rank[i] + RANK_W'(1);
          end
        end
        valid_next[slot] = 1'b1;
        rank_next[slot]  = '0;
        val_we           = 1'b1;
        key_we           = 1'b1;
        if (room || !lk.victim_ok) begin
          count_next = count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid  <= 1'b0;
      done     <= 1'b0;
      capacity <= lru_kvc_pkg::CAP_RESET;
      count    <= '0;
      valid    <= '0;
      rank     <= '0;
    end else begin
      s_valid <= start && !busy;
      done    <= s_valid;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      count <= count_next;
      valid <= valid_next;
      rank  <= rank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s_req <= req;
    end
    rsp <= rsp_next;
    if (val_we) begin
      values[wr_idx] <= s_req.value;
    end
    if (key_we) begin
      keys[wr_idx] <= s_req.key;
    end
  end

endmodule

[src/lru_kvc_chk.sv]
module lru_kvc_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input lru_kvc_pkg::req_t             req,
  input logic                          done,
  input lru_kvc_pkg::rsp_t             rsp
);

  logic acc;
  assign acc = start && !busy;

  // every taken beat must be followed by one done result
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    acc |=> ##1 done)
    else $error("result missing after accepted beat");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc, 2))
    else $error("result without accepted beat");

  a_put_zero: assert property (@(posedge clk) disable iff (rst)
    done && $past(req.opcode, 2) == lru_kvc_pkg::OP_PUT |-> rsp.read_value == '0)
    else $error("put returned nonzero value");

  a_get_miss: assert property (@(posedge clk) disable iff (rst)
    done && $past(req.opcode, 2) == lru_kvc_pkg::OP_GET && !rsp.hit
    |-> rsp.read_value == lru_kvc_pkg::MISS_VALUE)
    else $error("get miss value not all ones");

  // a put followed at once by a get of the same key must hit with that value
  a_put_then_get: assert property (@(posedge clk) disable iff (rst)
    done && !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3)
    && $past(acc, 3) && $past(acc, 2)
    && $past(req.opcode, 3) == lru_kvc_pkg::OP_PUT
    && $past(req.opcode, 2) == lru_kvc_pkg::OP_GET
    && $past(req.key, 3) == $past(req.key, 2)
    |-> rsp.hit && rsp.read_value == $past(req.value, 3))
    else $error("get after put of same key did not return put value");

endmodule

bind lru_key_value_cache lru_kvc_chk u_lru_kvc_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .req       (req),
  .done      (done),
  .rsp       (rsp)
);
